### hw/rtl/pme_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pme_pkg - shared types and constants of the port mailbox engine
// Holds the opcode, status and slot state codes and the sequencer states.
// ----------------------------------------------------------------------------
package pme_pkg;

   localparam int unsigned MAX_LENGTH = 4096;
   localparam int unsigned PORT_LIMIT = 1024;

   typedef enum logic [1:0] {
      OP_CREATE  = 2'd0,
      OP_DESTROY = 2'd1,
      OP_SEND    = 2'd2,
      OP_RECEIVE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_FAIL    = 2'd1,
      ST_BLOCKED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SLOT_FREE   = 2'd0,
      SLOT_ACTIVE = 2'd1,
      SLOT_CLOSED = 2'd2
   } slot_state_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_EXEC,
      FSM_READ,
      FSM_RESP
   } fsm_type;

endpackage : pme_pkg
`default_nettype wire

### hw/rtl/port_mailbox_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// port_mailbox_engine_top - port based message mailbox engine
// Slot table with per-slot ring queues, scanned one slot per cycle.
// ----------------------------------------------------------------------------
// Usage
//   req_ channel carries one operation per beat (create, destroy, send,
//   receive); rsp_ channel returns exactly one result beat per operation.
//   An operation is taken only while the engine is idle: req_stall is high
//   from acceptance until the result beat has been taken.
//   The accept edge starts a scan of every slot (a single shared
//   id/free compare walks the table one slot per cycle), then an execute
//   step and a message memory read step, which every operation passes
//   through; after the read step the result beat is presented.
//   While rsp_stall is high the result beat holds and no new request is
//   taken. Reset clears slot states, waiters, ring pointers and counters;
//   no clearing pass is needed, message memory data is only returned after
//   it has been written.
// ----------------------------------------------------------------------------
module port_mailbox_engine_top
   import pme_pkg::*;
#(
   parameter int unsigned SLOTS       = 16,
   parameter int unsigned QUEUE_DEPTH = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [31:0] req_port_ref,
   input  wire logic [31:0] req_pid,
   input  wire logic [31:0] req_reply_port,
   input  wire logic [2:0]  req_kind,
   input  wire logic [3:0]  req_access_rights,
   input  wire logic [12:0] req_length,
   input  wire logic [63:0] req_payload_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_new_port,
   output logic [2:0]       rsp_got_kind,
   output logic [31:0]      rsp_got_sender_pid,
   output logic [31:0]      rsp_got_sender_port,
   output logic [31:0]      rsp_got_dest_port,
   output logic [31:0]      rsp_got_msg_id,
   output logic [12:0]      rsp_got_length,
   output logic [63:0]      rsp_got_payload,
   output logic             rsp_woke,
   output logic [31:0]      rsp_woken_pid,
   output logic [10:0]      rsp_open_ports
);

   localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned CW = $clog2(SLOTS + 1);
   localparam int unsigned MD = SLOTS * (2 ** QW);
   localparam int unsigned MW = SW + QW;
   localparam int unsigned OW = $clog2(PORT_LIMIT + 1);

   // slot table
   slot_state_type    slot_status_ff [SLOTS];
   logic [31:0]       slot_port_id_ff [SLOTS];
   logic [31:0]       slot_owner_ff [SLOTS];
   logic [3:0]        slot_rights_ff [SLOTS];
   logic              waiter_valid_ff [SLOTS];
   logic [31:0]       waiter_pid_ff [SLOTS];
   logic [QW-1:0]     ring_head_ff [SLOTS];
   logic [QW-1:0]     ring_tail_ff [SLOTS];
   logic [FW-1:0]     ring_fill_ff [SLOTS];

   // message memory: payload plus header
   logic [63:0]       mem_payload [MD];
   logic [2:0]        mem_kind [MD];
   logic [31:0]       mem_spid [MD];
   logic [31:0]       mem_sport [MD];
   logic [31:0]       mem_dport [MD];
   logic [31:0]       mem_id [MD];
   logic [12:0]       mem_len [MD];

   logic [OW-1:0]     open_count_ff;
   logic [31:0]       next_port_ff;
   logic [31:0]       next_msg_ff;

   fsm_type           state_ff, state_in;
   logic [CW-1:0]     scan_ff;
   logic              found_ff;
   logic [SW-1:0]     hit_ff;

   // captured request
   opcode_type        op_ff;
   logic [31:0]       port_ref_ff, pid_ff, reply_ff;
   logic [2:0]        kind_ff;
   logic [3:0]        rights_ff;
   logic [12:0]       length_ff;
   logic [63:0]       payload_ff;

   // result beat
   logic [1:0]        r_status_ff;
   logic [31:0]       r_new_port_ff;
   logic              r_got_ff;
   logic              r_woke_ff;
   logic [31:0]       r_woken_ff;
   logic [2:0]        m_kind_ff;
   logic [31:0]       m_spid_ff, m_sport_ff, m_dport_ff, m_id_ff;
   logic [12:0]       m_len_ff;
   logic [63:0]       m_payload_ff;
   logic [MW-1:0]     rd_addr_ff;

   logic              accept;
   logic              scan_match;
   logic [SW-1:0]     scan_idx;
   logic [MW-1:0]     wr_addr;

   assign accept   = req_valid && !req_stall;
   assign scan_idx = scan_ff[SW-1:0];

   // shared compare: free slot for create, id match otherwise
   always_comb begin
      if (op_ff == OP_CREATE)
         scan_match = (slot_status_ff[scan_idx] == SLOT_FREE);
      else
         scan_match = (slot_status_ff[scan_idx] != SLOT_FREE) &&
                      (slot_port_id_ff[scan_idx] == port_ref_ff);
   end

   assign wr_addr = {hit_ff, ring_tail_ff[hit_ff]};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: if (req_valid) state_in = FSM_SCAN;
         FSM_SCAN: if (scan_ff == CW'(SLOTS - 1)) state_in = FSM_EXEC;
         FSM_EXEC: state_in = FSM_READ;
         FSM_READ: state_in = FSM_RESP;
         FSM_RESP: if (!rsp_stall) state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = (state_ff != FSM_IDLE);
      rsp_valid = (state_ff == FSM_RESP);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= FSM_IDLE;
      else       state_ff <= state_in;
   end

   // request capture and slot scan
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= opcode_type'(req_opcode);
         port_ref_ff <= req_port_ref;
         pid_ff      <= req_pid;
         reply_ff    <= req_reply_port;
         kind_ff     <= req_kind;
         rights_ff   <= req_access_rights;
         length_ff   <= req_length;
         payload_ff  <= req_payload_word;
      end
      if (reset) begin
         scan_ff  <= '0;
         found_ff <= 1'b0;
      end else if (accept) begin
         scan_ff  <= '0;
         found_ff <= 1'b0;
      end else if (state_ff == FSM_SCAN) begin
         scan_ff <= scan_ff + CW'(1);
         if (scan_match && !found_ff) begin
            found_ff <= 1'b1;
            hit_ff   <= scan_idx;
         end
      end
   end

   // execute step: table update and result
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_status_ff[i]  <= SLOT_FREE;
            waiter_valid_ff[i] <= 1'b0;
            ring_head_ff[i]    <= '0;
            ring_tail_ff[i]    <= '0;
            ring_fill_ff[i]    <= '0;
         end
         open_count_ff <= '0;
         next_port_ff  <= 32'd1;
         next_msg_ff   <= 32'd1;
         r_got_ff      <= 1'b0;
      end else if (state_ff == FSM_EXEC) begin
         r_status_ff   <= ST_FAIL;
         r_new_port_ff <= '0;
         r_got_ff      <= 1'b0;
         r_woke_ff     <= 1'b0;
         r_woken_ff    <= '0;
         case (op_ff)
            OP_CREATE: begin
               if (found_ff && open_count_ff < OW'(PORT_LIMIT)) begin
                  slot_status_ff[hit_ff]  <= SLOT_ACTIVE;
                  slot_port_id_ff[hit_ff] <= next_port_ff;
                  slot_owner_ff[hit_ff]   <= pid_ff;
                  slot_rights_ff[hit_ff]  <= rights_ff;
                  ring_head_ff[hit_ff]    <= '0;
                  ring_tail_ff[hit_ff]    <= '0;
                  ring_fill_ff[hit_ff]    <= '0;
                  waiter_valid_ff[hit_ff] <= 1'b0;
                  next_port_ff  <= next_port_ff + 32'd1;
                  open_count_ff <= open_count_ff + OW'(1);
                  r_status_ff   <= ST_DONE;
                  r_new_port_ff <= next_port_ff;
               end
            end
            OP_DESTROY: begin
               if (found_ff && slot_owner_ff[hit_ff] == pid_ff) begin
                  slot_status_ff[hit_ff] <= SLOT_CLOSED;
                  if (open_count_ff != '0) open_count_ff <= open_count_ff - OW'(1);
                  r_status_ff <= ST_DONE;
               end
            end
            OP_SEND: begin
               if (length_ff <= 13'(MAX_LENGTH) && found_ff &&
                   slot_status_ff[hit_ff] == SLOT_ACTIVE) begin
                  next_msg_ff <= next_msg_ff + 32'd1;
                  if (ring_fill_ff[hit_ff] < FW'(QUEUE_DEPTH)) begin
                     ring_tail_ff[hit_ff] <= (ring_tail_ff[hit_ff] == QW'(QUEUE_DEPTH - 1))
                                             ? '0 : ring_tail_ff[hit_ff] + QW'(1);
                     ring_fill_ff[hit_ff] <= ring_fill_ff[hit_ff] + FW'(1);
                     r_status_ff <= ST_DONE;
                     if (waiter_valid_ff[hit_ff]) begin
                        r_woke_ff  <= 1'b1;
                        r_woken_ff <= waiter_pid_ff[hit_ff];
                        waiter_valid_ff[hit_ff] <= 1'b0;
                     end
                  end
               end
            end
            OP_RECEIVE: begin
               if (found_ff && slot_owner_ff[hit_ff] == pid_ff) begin
                  if (ring_fill_ff[hit_ff] != '0) begin
                     rd_addr_ff <= {hit_ff, ring_head_ff[hit_ff]};
                     ring_head_ff[hit_ff] <= (ring_head_ff[hit_ff] == QW'(QUEUE_DEPTH - 1))
                                             ? '0 : ring_head_ff[hit_ff] + QW'(1);
                     ring_fill_ff[hit_ff] <= ring_fill_ff[hit_ff] - FW'(1);
                     r_status_ff <= ST_DONE;
                     r_got_ff    <= 1'b1;
                  end else begin
                     waiter_valid_ff[hit_ff] <= 1'b1;
                     waiter_pid_ff[hit_ff]   <= pid_ff;
                     r_status_ff <= ST_BLOCKED;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // message memory write on a queued send
   always_ff @(posedge clock) begin
      if (state_ff == FSM_EXEC && op_ff == OP_SEND && found_ff &&
          length_ff <= 13'(MAX_LENGTH) && slot_status_ff[hit_ff] == SLOT_ACTIVE &&
          ring_fill_ff[hit_ff] < FW'(QUEUE_DEPTH)) begin
         mem_payload[wr_addr] <= payload_ff;
         mem_kind[wr_addr]    <= kind_ff;
         mem_spid[wr_addr]    <= pid_ff;
         mem_sport[wr_addr]   <= reply_ff;
         mem_dport[wr_addr]   <= port_ref_ff;
         mem_id[wr_addr]      <= next_msg_ff;
         mem_len[wr_addr]     <= length_ff;
      end
   end

   // registered memory read
   always_ff @(posedge clock) begin
      if (state_ff == FSM_READ) begin
         m_payload_ff <= mem_payload[rd_addr_ff];
         m_kind_ff    <= mem_kind[rd_addr_ff];
         m_spid_ff    <= mem_spid[rd_addr_ff];
         m_sport_ff   <= mem_sport[rd_addr_ff];
         m_dport_ff   <= mem_dport[rd_addr_ff];
         m_id_ff      <= mem_id[rd_addr_ff];
         m_len_ff     <= mem_len[rd_addr_ff];
      end
   end

   // result beat
   assign rsp_status          = r_status_ff;
   assign rsp_new_port        = r_new_port_ff;
   assign rsp_got_kind        = r_got_ff ? m_kind_ff : '0;
   assign rsp_got_sender_pid  = r_got_ff ? m_spid_ff : '0;
   assign rsp_got_sender_port = r_got_ff ? m_sport_ff : '0;
   assign rsp_got_dest_port   = r_got_ff ? m_dport_ff : '0;
   assign rsp_got_msg_id      = r_got_ff ? m_id_ff : '0;
   assign rsp_got_length      = r_got_ff ? m_len_ff : '0;
   assign rsp_got_payload     = r_got_ff ? m_payload_ff : '0;
   assign rsp_woke            = r_woke_ff;
   assign rsp_woken_pid       = r_woken_ff;
   assign rsp_open_ports      = 11'(open_count_ff);

endmodule : port_mailbox_engine_top
`default_nettype wire

### hw/rtl/pme_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pme_checker - port level checks of the port mailbox engine
// Watches the request and result channels and the result fields.
// ----------------------------------------------------------------------------
module pme_checker
   import pme_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic [31:0] rsp_new_port,
   input wire logic        rsp_woke,
   input wire logic [31:0] rsp_woken_pid
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("result beat changed under stall");

   // no request taken while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken with result pending");

   // a request beat is followed by a stall
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("engine not busy after request");

   // wake only reported on a completed operation
   a_wake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_woke |-> rsp_status == ST_DONE && rsp_new_port == '0)
      else $error("wake on failed operation");

   // woken pid is zero without a wake
   a_wpid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_woke |-> rsp_woken_pid == '0)
      else $error("woken pid without wake");

endmodule : pme_checker

bind port_mailbox_engine_top pme_checker u_pme_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_status(rsp_status), .rsp_new_port(rsp_new_port),
   .rsp_woke(rsp_woke), .rsp_woken_pid(rsp_woken_pid)
);
`default_nettype wire
